// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPLY(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/pbcf_pkg.sv =====
// ----------------------------------------------------------------------------
// pbcf_pkg
// constants shared by the palette fader and its checker
// ----------------------------------------------------------------------------
package pbcf_pkg;

  // palette and field widths
  localparam int PALETTE_SIZE = 6;
  localparam int PAL_AW       = 3;
  localparam int COLOR_W      = 24;
  localparam int CHAN_W       = 8;
  localparam int PHASE_W      = 16;
  localparam int RATE_W       = 16;
  localparam int COUNT_W      = 3;
  localparam int ELAPSED_W    = 10;

  // stream and config port widths
  localparam int IN_DATA_W    = 16;
  localparam int OUT_DATA_W   = 24;
  localparam int CFG_IDX_W    = 4;
  localparam int CFG_DATA_W   = 24;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STEP_RATE   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_COUNT = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_0     = 4'd2;

  // serial multiplier geometry: 32-bit multiplicand, 18-bit multiplier
  localparam int MC_W       = 32;
  localparam int ML_W       = 18;
  localparam int MP_W       = MC_W + ML_W;
  localparam int MUL_STEPS  = ML_W;
  localparam int LANE_STEPS = PHASE_W;
  localparam int LANE_W     = CHAN_W + PHASE_W;

  // smoothstep uses t^2 * (3*2^16 - 2t) >> 32
  localparam int SMOOTH_K   = 3 * 65536;

endpackage

// ===== rtl/palette_breath_color_fader_top.sv =====
// ----------------------------------------------------------------------------
// palette_breath_color_fader_top
// per-frame palette fade with smoothstep easing, bit-serial arithmetic
// ----------------------------------------------------------------------------
// usage:
//   in_*  : one transfer per display frame, tdata[9:0] = elapsed milliseconds
//   out_* : one transfer per frame, tdata = {blue, green, red}, red lowest
//   cfg_* : register writes (0 step_rate, 1 color_count, 2..7 color_0..5),
//           cfg_ready is always high, write only while the block is idle
// timing:
//   one shared shift-add multiplier takes one multiplier bit per cycle:
//   rate*elapsed, then t*t, then t^2*(3-2t); three 8-bit blend lanes then
//   run on the curve value. a new input is accepted only while idle, from
//   the cycle after the result is loaded, so frames never overlap.
// reset:
//   rst_n low clears phase, palette index, step_rate and palette valid bits,
//   and sets color_count to 1 (colors read as zero until written).
// stall:
//   the result sits in an output register; a new frame is accepted while it
//   waits, but its own result holds in the last step until the slot frees.
// ----------------------------------------------------------------------------
module palette_breath_color_fader_top
  import pbcf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata: elapsed_ms[9:0], zero fill above
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // out_tdata: red[7:0], green[15:8], blue[23:16]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  // config write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // sequencer codes
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PMUL = 4'd1;
  localparam logic [3:0] S_PADD = 4'd2;
  localparam logic [3:0] S_SQ   = 4'd3;
  localparam logic [3:0] S_CSET = 4'd4;
  localparam logic [3:0] S_CUBE = 4'd5;
  localparam logic [3:0] S_RD0  = 4'd6;
  localparam logic [3:0] S_RD1  = 4'd7;
  localparam logic [3:0] S_RD2  = 4'd8;
  localparam logic [3:0] S_LANE = 4'd9;
  localparam logic [3:0] S_FIN  = 4'd10;

  localparam logic [4:0] MUL_LAST  = 5'(MUL_STEPS - 1);
  localparam logic [4:0] LANE_LAST = 5'(LANE_STEPS - 1);

  // control state
  logic [3:0]          state_r, state_nxt;
  logic [4:0]          cnt_r, cnt_nxt;
  logic [PHASE_W-1:0]  phase_r, phase_nxt;
  logic [PAL_AW-1:0]   idx_r, idx_nxt;
  logic [RATE_W-1:0]   step_rate_r;
  logic [COUNT_W-1:0]  count_r;
  logic [PALETTE_SIZE-1:0] col_vld_r;
  logic                out_valid_r, out_valid_nxt;

  // datapath
  logic [MP_W-1:0]     mp_r, mp_nxt;
  logic [MC_W-1:0]     mcand_r, mcand_nxt;
  logic [COLOR_W-1:0]  c0_r, c0_nxt;
  logic [COLOR_W-1:0]  rd_r;
  logic [LANE_W-1:0]   lp_r [3];
  logic [LANE_W-1:0]   lp_nxt [3];
  logic [CHAN_W-1:0]   d_r [3];
  logic [CHAN_W-1:0]   d_nxt [3];
  logic [2:0]          neg_r, neg_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // palette storage
  logic [COLOR_W-1:0]  color_mem [PALETTE_SIZE];
  logic [PAL_AW-1:0]   rd_addr;
  logic [PAL_AW-1:0]   wr_addr;
  logic                wr_color;

  // helpers
  logic                in_xfer;
  logic [PAL_AW-1:0]   n_eff;
  logic [PAL_AW-1:0]   idx_inc;
  logic [PAL_AW-1:0]   idx_next;
  logic [MC_W:0]       mul_sum;
  logic [MP_W-1:0]     mul_step;
  logic [26:0]         phase_sum;
  logic [ML_W-1:0]     u_val;
  logic                slot_free;

  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign slot_free  = !out_valid_r || out_tready;

  // effective color count, clamped to 1..PALETTE_SIZE
  always_comb begin
    if (count_r == '0) begin
      n_eff = PAL_AW'(1);
    end else if (count_r > COUNT_W'(PALETTE_SIZE)) begin
      n_eff = PAL_AW'(PALETTE_SIZE);
    end else begin
      n_eff = count_r;
    end
  end

  // neighbor of the current index, wrapping at the count
  assign idx_inc  = idx_r + PAL_AW'(1);
  assign idx_next = (idx_inc >= n_eff) ? '0 : idx_inc;

  // one shift-add step of the shared multiplier
  assign mul_sum  = {1'b0, mp_r[MP_W-1:ML_W]} + {1'b0, mcand_r};
  assign mul_step = mp_r[0] ? {mul_sum, mp_r[ML_W-1:1]} : {1'b0, mp_r[MP_W-1:1]};

  assign phase_sum = mp_r[26:0] + {11'b0, phase_r};
  assign u_val     = ML_W'(SMOOTH_K) - {1'b0, phase_r, 1'b0};

  // palette read address: current color first, then its neighbor
  assign rd_addr = (state_r == S_RD0) ? idx_r : idx_next;

  // config decode for the color registers
  assign wr_color = cfg_valid && (cfg_index >= REG_COLOR_0) &&
                    (cfg_index < REG_COLOR_0 + CFG_IDX_W'(PALETTE_SIZE));
  assign wr_addr  = PAL_AW'(cfg_index - REG_COLOR_0);

  // sequencer and datapath next values
  always_comb begin
    logic [CHAN_W-1:0] ca, cb;
    logic [CHAN_W:0]   lsum;
    logic [CHAN_W-1:0] hi, ceil_hi;
    ca            = '0;
    cb            = '0;
    lsum          = '0;
    hi            = '0;
    ceil_hi       = '0;
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    phase_nxt     = phase_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    mp_nxt        = mp_r;
    mcand_nxt     = mcand_r;
    c0_nxt        = c0_r;
    neg_nxt       = neg_r;
    out_data_nxt  = out_data_r;
    for (int k = 0; k < 3; k++) begin
      lp_nxt[k] = lp_r[k];
      d_nxt[k]  = d_r[k];
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          mp_nxt    = {{(MC_W + ML_W - ELAPSED_W){1'b0}}, in_tdata[ELAPSED_W-1:0]};
          mcand_nxt = {{(MC_W - RATE_W){1'b0}}, step_rate_r};
          idx_nxt   = (idx_r >= n_eff) ? '0 : idx_r;
          cnt_nxt   = '0;
          state_nxt = S_PMUL;
        end
      end
      S_PMUL, S_SQ, S_CUBE: begin
        mp_nxt  = mul_step;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == MUL_LAST) begin
          cnt_nxt = '0;
          case (state_r)
            S_PMUL:  state_nxt = S_PADD;
            S_SQ:    state_nxt = S_CSET;
            default: state_nxt = S_RD0;
          endcase
        end
      end
      S_PADD: begin
        // phase update, wrap to the next color on reaching one
        if (phase_sum[26:PHASE_W] != '0) begin
          phase_nxt = '0;
          idx_nxt   = idx_next;
          mp_nxt    = '0;
          mcand_nxt = '0;
        end else begin
          phase_nxt = phase_sum[PHASE_W-1:0];
          mp_nxt    = {{(MP_W - PHASE_W){1'b0}}, phase_sum[PHASE_W-1:0]};
          mcand_nxt = {{(MC_W - PHASE_W){1'b0}}, phase_sum[PHASE_W-1:0]};
        end
        state_nxt = S_SQ;
      end
      S_CSET: begin
        // t^2 becomes the multiplicand, (3 - 2t) the multiplier
        mcand_nxt = mp_r[MC_W-1:0];
        mp_nxt    = {{MC_W{1'b0}}, u_val};
        state_nxt = S_CUBE;
      end
      S_RD0: begin
        state_nxt = S_RD1;
      end
      S_RD1: begin
        c0_nxt    = rd_r;
        state_nxt = S_RD2;
      end
      S_RD2: begin
        // lane setup: magnitude and sign of each channel difference
        for (int k = 0; k < 3; k++) begin
          ca         = c0_r[CHAN_W*k +: CHAN_W];
          cb         = rd_r[CHAN_W*k +: CHAN_W];
          neg_nxt[k] = (cb < ca);
          d_nxt[k]   = (cb < ca) ? (ca - cb) : (cb - ca);
          lp_nxt[k]  = {{CHAN_W{1'b0}}, mp_r[47:32]};
        end
        cnt_nxt   = '0;
        state_nxt = S_LANE;
      end
      S_LANE: begin
        for (int k = 0; k < 3; k++) begin
          lsum      = {1'b0, lp_r[k][LANE_W-1:PHASE_W]} + {1'b0, d_r[k]};
          lp_nxt[k] = lp_r[k][0] ? {lsum, lp_r[k][PHASE_W-1:1]}
                                 : {1'b0, lp_r[k][LANE_W-1:1]};
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == LANE_LAST) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          // red from bits 23:16 of the colors goes to the lowest output byte
          for (int k = 0; k < 3; k++) begin
            ca      = c0_r[CHAN_W*k +: CHAN_W];
            hi      = lp_r[k][LANE_W-1:PHASE_W];
            ceil_hi = hi + CHAN_W'(lp_r[k][PHASE_W-1:0] != '0);
            out_data_nxt[CHAN_W*(2-k) +: CHAN_W] = neg_r[k] ? (ca - ceil_hi) : (ca + hi);
          end
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      phase_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      step_rate_r <= '0;
      count_r     <= COUNT_W'(1);
      col_vld_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      phase_r     <= phase_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_index == REG_STEP_RATE) begin
        step_rate_r <= cfg_data[RATE_W-1:0];
      end
      if (cfg_valid && cfg_index == REG_COLOR_COUNT) begin
        count_r <= cfg_data[COUNT_W-1:0];
      end
      if (wr_color) begin
        col_vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    mp_r       <= mp_nxt;
    mcand_r    <= mcand_nxt;
    c0_r       <= c0_nxt;
    neg_r      <= neg_nxt;
    out_data_r <= out_data_nxt;
    for (int k = 0; k < 3; k++) begin
      lp_r[k] <= lp_nxt[k];
      d_r[k]  <= d_nxt[k];
    end
  end

  // palette memory write
  always_ff @(posedge clk) begin
    if (wr_color) begin
      color_mem[wr_addr] <= cfg_data;
    end
  end

  // palette memory registered read, unwritten entries read as zero
  always_ff @(posedge clk) begin
    rd_r <= col_vld_r[rd_addr] ? color_mem[rd_addr] : '0;
  end

endmodule

// ===== rtl/pbcf_checker.sv =====
// ----------------------------------------------------------------------------
// pbcf_checker
// port-level checks on the palette fader, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pbcf_checker
  import pbcf_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // a stalled result stays offered
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)

  // a stalled result keeps its value
  `ASSERT_NEXT(a_out_stable, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata))

  // the block is busy right after taking a frame
  `ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_tvalid && in_tready, !in_tready)

  // a result never appears the cycle after its frame transfer
  `ASSERT_NEXT(a_no_instant_out, clk, rst_n, in_tvalid && in_tready && !out_tvalid,
               !out_tvalid)

endmodule

bind palette_breath_color_fader_top pbcf_checker u_pbcf_checker (.*);
